/* sv/bloch_rk4_step_top_assert.svh */
// Assertion macros for the Bloch RK4 step block.
`ifndef BLOCH_RK4_STEP_TOP_ASSERT_SVH
`define BLOCH_RK4_STEP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define BRK4_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("brk4 same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define BRK4_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("brk4 next-cycle check failed");
`else
`define BRK4_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BRK4_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* sv/brk4_pkg.sv */
// Shared types, codes and microprogram of the Bloch RK4 step block.
package brk4_pkg;

	// Default geometry
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 28;
	localparam logic [63:0] STEP_RESET_DEF = 64'd3676500;

	// Configuration register indexes
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_TF   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_XI   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_STEP = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_IU   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_IV   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_IW   = 3'd5;

	// Datapath operations
	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_NEG  = 2'd1;
	localparam logic [1:0] OP_MUL  = 2'd2;
	localparam logic [1:0] OP_DIV6 = 2'd3;

	// Phases of one operation
	localparam logic [1:0] PH_READ  = 2'd0;
	localparam logic [1:0] PH_EXEC  = 2'd1;
	localparam logic [1:0] PH_POST  = 2'd2;
	localparam logic [1:0] PH_WRITE = 2'd3;

	// Scratch memory geometry
	localparam int MEM_AW = 5;
	localparam int OPD_W  = MEM_AW + 1;

	// Operand codes: top bit clear selects a scratch slot
	localparam logic [OPD_W-1:0] O_XI2 = 6'd0;
	localparam logic [OPD_W-1:0] O_P   = 6'd1;
	localparam logic [OPD_W-1:0] O_A   = 6'd2;
	localparam logic [OPD_W-1:0] O_B   = 6'd3;
	localparam logic [OPD_W-1:0] O_K1U = 6'd4;
	localparam logic [OPD_W-1:0] O_K1V = 6'd5;
	localparam logic [OPD_W-1:0] O_K1W = 6'd6;
	localparam logic [OPD_W-1:0] O_K2U = 6'd7;
	localparam logic [OPD_W-1:0] O_K2V = 6'd8;
	localparam logic [OPD_W-1:0] O_K2W = 6'd9;
	localparam logic [OPD_W-1:0] O_K3U = 6'd10;
	localparam logic [OPD_W-1:0] O_K3V = 6'd11;
	localparam logic [OPD_W-1:0] O_K3W = 6'd12;
	localparam logic [OPD_W-1:0] O_K4U = 6'd13;
	localparam logic [OPD_W-1:0] O_K4V = 6'd14;
	localparam logic [OPD_W-1:0] O_K4W = 6'd15;
	localparam logic [OPD_W-1:0] O_TU  = 6'd16;
	localparam logic [OPD_W-1:0] O_TV  = 6'd17;
	localparam logic [OPD_W-1:0] O_TW  = 6'd18;
	localparam logic [OPD_W-1:0] O_Q   = 6'd19;
	localparam logic [OPD_W-1:0] O_S   = 6'd20;
	// Top bit set selects a register outside the scratch memory
	localparam logic [OPD_W-1:0] O_TF  = 6'd32;
	localparam logic [OPD_W-1:0] O_XI  = 6'd33;
	localparam logic [OPD_W-1:0] O_R   = 6'd34;
	localparam logic [OPD_W-1:0] O_H   = 6'd35;
	localparam logic [OPD_W-1:0] O_HH  = 6'd36;
	localparam logic [OPD_W-1:0] O_U   = 6'd37;
	localparam logic [OPD_W-1:0] O_V   = 6'd38;
	localparam logic [OPD_W-1:0] O_W   = 6'd39;

	// Microprogram length
	localparam int PROG_LEN = 74;
	localparam int PC_W     = 7;

	typedef struct packed {
		logic [1:0]       op;
		logic [OPD_W-1:0] src_a;
		logic [OPD_W-1:0] src_b;
		logic [OPD_W-1:0] dst;
	} uop_t;

	typedef struct packed {
		logic       start;
		logic       restart;
		logic       run;
		logic [1:0] phase;
		uop_t       uop;
		logic       out_load;
	} cmd_t;

	// -1.0 in the chosen format, clamped to the negative limit
	function automatic logic [63:0] minus_one(input int dw, input int fb);
		logic [63:0] m;
		if (fb < dw - 1) begin
			m = ~64'd0 << fb;
		end else begin
			m = ~64'd0 << (dw - 1);
		end
		return m;
	endfunction

	function automatic uop_t mk(input logic [1:0] op, input logic [OPD_W-1:0] a,
			input logic [OPD_W-1:0] b, input logic [OPD_W-1:0] d);
		uop_t u;
		u.op    = op;
		u.src_a = a;
		u.src_b = b;
		u.dst   = d;
		return u;
	endfunction

	// One RK4 step: coefficients, four slope evaluations, combination
	function automatic uop_t prog(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			// a = w0 + 2*xi*r, b = 2*r
			7'd0:  u = mk(OP_ADD,  O_XI,  O_XI,  O_XI2);
			7'd1:  u = mk(OP_MUL,  O_XI2, O_R,   O_P);
			7'd2:  u = mk(OP_ADD,  O_TF,  O_P,   O_A);
			7'd3:  u = mk(OP_ADD,  O_R,   O_R,   O_B);
			// k1 = f(y)
			7'd4:  u = mk(OP_MUL,  O_A,   O_V,   O_P);
			7'd5:  u = mk(OP_NEG,  O_P,   O_P,   O_K1U);
			7'd6:  u = mk(OP_MUL,  O_A,   O_U,   O_P);
			7'd7:  u = mk(OP_MUL,  O_B,   O_W,   O_Q);
			7'd8:  u = mk(OP_NEG,  O_Q,   O_Q,   O_Q);
			7'd9:  u = mk(OP_ADD,  O_P,   O_Q,   O_K1V);
			7'd10: u = mk(OP_MUL,  O_B,   O_V,   O_K1W);
			// t = y + h/2*k1
			7'd11: u = mk(OP_MUL,  O_HH,  O_K1U, O_P);
			7'd12: u = mk(OP_ADD,  O_U,   O_P,   O_TU);
			7'd13: u = mk(OP_MUL,  O_HH,  O_K1V, O_P);
			7'd14: u = mk(OP_ADD,  O_V,   O_P,   O_TV);
			7'd15: u = mk(OP_MUL,  O_HH,  O_K1W, O_P);
			7'd16: u = mk(OP_ADD,  O_W,   O_P,   O_TW);
			// k2 = f(t)
			7'd17: u = mk(OP_MUL,  O_A,   O_TV,  O_P);
			7'd18: u = mk(OP_NEG,  O_P,   O_P,   O_K2U);
			7'd19: u = mk(OP_MUL,  O_A,   O_TU,  O_P);
			7'd20: u = mk(OP_MUL,  O_B,   O_TW,  O_Q);
			7'd21: u = mk(OP_NEG,  O_Q,   O_Q,   O_Q);
			7'd22: u = mk(OP_ADD,  O_P,   O_Q,   O_K2V);
			7'd23: u = mk(OP_MUL,  O_B,   O_TV,  O_K2W);
			// t = y + h/2*k2
			7'd24: u = mk(OP_MUL,  O_HH,  O_K2U, O_P);
			7'd25: u = mk(OP_ADD,  O_U,   O_P,   O_TU);
			7'd26: u = mk(OP_MUL,  O_HH,  O_K2V, O_P);
			7'd27: u = mk(OP_ADD,  O_V,   O_P,   O_TV);
			7'd28: u = mk(OP_MUL,  O_HH,  O_K2W, O_P);
			7'd29: u = mk(OP_ADD,  O_W,   O_P,   O_TW);
			// k3 = f(t)
			7'd30: u = mk(OP_MUL,  O_A,   O_TV,  O_P);
			7'd31: u = mk(OP_NEG,  O_P,   O_P,   O_K3U);
			7'd32: u = mk(OP_MUL,  O_A,   O_TU,  O_P);
			7'd33: u = mk(OP_MUL,  O_B,   O_TW,  O_Q);
			7'd34: u = mk(OP_NEG,  O_Q,   O_Q,   O_Q);
			7'd35: u = mk(OP_ADD,  O_P,   O_Q,   O_K3V);
			7'd36: u = mk(OP_MUL,  O_B,   O_TV,  O_K3W);
			// t = y + h*k3
			7'd37: u = mk(OP_MUL,  O_H,   O_K3U, O_P);
			7'd38: u = mk(OP_ADD,  O_U,   O_P,   O_TU);
			7'd39: u = mk(OP_MUL,  O_H,   O_K3V, O_P);
			7'd40: u = mk(OP_ADD,  O_V,   O_P,   O_TV);
			7'd41: u = mk(OP_MUL,  O_H,   O_K3W, O_P);
			7'd42: u = mk(OP_ADD,  O_W,   O_P,   O_TW);
			// k4 = f(t)
			7'd43: u = mk(OP_MUL,  O_A,   O_TV,  O_P);
			7'd44: u = mk(OP_NEG,  O_P,   O_P,   O_K4U);
			7'd45: u = mk(OP_MUL,  O_A,   O_TU,  O_P);
			7'd46: u = mk(OP_MUL,  O_B,   O_TW,  O_Q);
			7'd47: u = mk(OP_NEG,  O_Q,   O_Q,   O_Q);
			7'd48: u = mk(OP_ADD,  O_P,   O_Q,   O_K4V);
			7'd49: u = mk(OP_MUL,  O_B,   O_TV,  O_K4W);
			// u += h*(k1 + 2k2 + 2k3 + k4)/6
			7'd50: u = mk(OP_ADD,  O_K2U, O_K2U, O_P);
			7'd51: u = mk(OP_ADD,  O_K3U, O_K3U, O_Q);
			7'd52: u = mk(OP_ADD,  O_Q,   O_K4U, O_Q);
			7'd53: u = mk(OP_ADD,  O_P,   O_Q,   O_P);
			7'd54: u = mk(OP_ADD,  O_K1U, O_P,   O_S);
			7'd55: u = mk(OP_MUL,  O_H,   O_S,   O_S);
			7'd56: u = mk(OP_DIV6, O_S,   O_S,   O_S);
			7'd57: u = mk(OP_ADD,  O_U,   O_S,   O_U);
			// v update
			7'd58: u = mk(OP_ADD,  O_K2V, O_K2V, O_P);
			7'd59: u = mk(OP_ADD,  O_K3V, O_K3V, O_Q);
			7'd60: u = mk(OP_ADD,  O_Q,   O_K4V, O_Q);
			7'd61: u = mk(OP_ADD,  O_P,   O_Q,   O_P);
			7'd62: u = mk(OP_ADD,  O_K1V, O_P,   O_S);
			7'd63: u = mk(OP_MUL,  O_H,   O_S,   O_S);
			7'd64: u = mk(OP_DIV6, O_S,   O_S,   O_S);
			7'd65: u = mk(OP_ADD,  O_V,   O_S,   O_V);
			// w update
			7'd66: u = mk(OP_ADD,  O_K2W, O_K2W, O_P);
			7'd67: u = mk(OP_ADD,  O_K3W, O_K3W, O_Q);
			7'd68: u = mk(OP_ADD,  O_Q,   O_K4W, O_Q);
			7'd69: u = mk(OP_ADD,  O_P,   O_Q,   O_P);
			7'd70: u = mk(OP_ADD,  O_K1W, O_P,   O_S);
			7'd71: u = mk(OP_MUL,  O_H,   O_S,   O_S);
			7'd72: u = mk(OP_DIV6, O_S,   O_S,   O_S);
			7'd73: u = mk(OP_ADD,  O_W,   O_S,   O_W);
			default: u = mk(OP_ADD, O_P, O_P, O_P);
		endcase
		return u;
	endfunction

endpackage

/* sv/brk4_regs.sv */
// Configuration register file with its APB-style access port.
module brk4_regs #(
	parameter int DATA_WIDTH = brk4_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = brk4_pkg::FRAC_BITS_DEF,
	parameter int APB_DW     = 32,
	parameter int ASTEP      = 2,
	parameter int AW         = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [AW-1:0]         paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready,
	output logic [DATA_WIDTH-1:0] transition_freq,
	output logic [DATA_WIDTH-1:0] dipole_asymmetry,
	output logic [DATA_WIDTH-2:0] step_size,
	output logic [DATA_WIDTH-1:0] init_u,
	output logic [DATA_WIDTH-1:0] init_v,
	output logic [DATA_WIDTH-1:0] init_w
);

	localparam int DW = DATA_WIDTH;
	localparam logic [DW-1:0] MINUS_ONE = DW'(brk4_pkg::minus_one(DW, FRAC_BITS));
	localparam logic [DW-2:0] STEP_RST  = (DW-1)'(brk4_pkg::STEP_RESET_DEF);

	logic [brk4_pkg::REG_IDX_W-1:0] idx;
	logic                           wr_en;
	logic [DW-1:0]                  wdata;
	logic [DW-1:0] tf_q, xi_q, iu_q, iv_q, iw_q;
	logic [DW-2:0] step_q;

	assign idx    = paddr[AW-1:ASTEP];
	assign wr_en  = psel && penable && pwrite && pready;
	assign wdata  = pwdata[DW-1:0];
	assign pready = 1'b1;

	// Write registers, dropping unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tf_q   <= '0;
			xi_q   <= '0;
			step_q <= STEP_RST;
			iu_q   <= '0;
			iv_q   <= '0;
			iw_q   <= MINUS_ONE;
		end else if (wr_en) begin
			unique case (idx)
				brk4_pkg::REG_TF:   tf_q   <= wdata;
				brk4_pkg::REG_XI:   xi_q   <= wdata;
				brk4_pkg::REG_STEP: step_q <= wdata[DW-2:0];
				brk4_pkg::REG_IU:   iu_q   <= wdata;
				brk4_pkg::REG_IV:   iv_q   <= wdata;
				brk4_pkg::REG_IW:   iw_q   <= wdata;
				default: ;
			endcase
		end
	end

	// Read back, sign-extending the signed registers
	always_comb begin
		unique case (idx)
			brk4_pkg::REG_TF:   prdata = APB_DW'($signed(tf_q));
			brk4_pkg::REG_XI:   prdata = APB_DW'($signed(xi_q));
			brk4_pkg::REG_STEP: prdata = APB_DW'(step_q);
			brk4_pkg::REG_IU:   prdata = APB_DW'($signed(iu_q));
			brk4_pkg::REG_IV:   prdata = APB_DW'($signed(iv_q));
			brk4_pkg::REG_IW:   prdata = APB_DW'($signed(iw_q));
			default:            prdata = '0;
		endcase
	end

	assign transition_freq  = tf_q;
	assign dipole_asymmetry = xi_q;
	assign step_size        = step_q;
	assign init_u           = iu_q;
	assign init_v           = iv_q;
	assign init_w           = iw_q;

endmodule

/* sv/brk4_ctrl.sv */
// Sequencer: stream handshakes, microprogram counter and phase control.
module brk4_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tuser,
	output logic            s_tready,
	input  logic            m_tready,
	output logic            m_tvalid,
	output brk4_pkg::cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [brk4_pkg::PC_W-1:0] PC_LAST = brk4_pkg::PC_W'(brk4_pkg::PROG_LEN - 1);

	logic [1:0]                state_q;
	logic [1:0]                ph_q;
	logic [brk4_pkg::PC_W-1:0] pc_q;
	logic                      out_valid_q;
	logic                      out_load;

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || m_tready);

	// Advance through the microprogram, four phases per operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= brk4_pkg::PH_READ;
			pc_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_RUN;
						ph_q    <= brk4_pkg::PH_READ;
						pc_q    <= '0;
					end
				end
				ST_RUN: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == brk4_pkg::PH_WRITE) begin
						if (pc_q == PC_LAST) begin
							state_q <= ST_FIN;
						end else begin
							pc_q <= pc_q + 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the result word until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Drive datapath commands
	always_comb begin
		s_tready     = (state_q == ST_IDLE);
		cmd.start    = s_tready && s_tvalid;
		cmd.restart  = s_tuser;
		cmd.run      = (state_q == ST_RUN);
		cmd.phase    = ph_q;
		cmd.uop      = brk4_pkg::prog(pc_q);
		cmd.out_load = out_load;
	end

	assign m_tvalid = out_valid_q;

endmodule

/* sv/brk4_dp.sv */
// Datapath: scratch memory, shared multiplier, saturating adder and state.
module brk4_dp #(
	parameter int DATA_WIDTH = brk4_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = brk4_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  brk4_pkg::cmd_t        cmd,
	input  logic [DATA_WIDTH-1:0] rabi_freq,
	input  logic [DATA_WIDTH-1:0] transition_freq,
	input  logic [DATA_WIDTH-1:0] dipole_asymmetry,
	input  logic [DATA_WIDTH-2:0] step_size,
	input  logic [DATA_WIDTH-1:0] init_u,
	input  logic [DATA_WIDTH-1:0] init_v,
	input  logic [DATA_WIDTH-1:0] init_w,
	output logic [DATA_WIDTH-1:0] u_out,
	output logic [DATA_WIDTH-1:0] v_out,
	output logic [DATA_WIDTH-1:0] w_out,
	output logic                  overflow
);

	localparam int DW = DATA_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int PW = 2 * DW;
	localparam int MW = PW - FB;
	localparam int QW = DW - 2;
	localparam int MEM_DEPTH = 1 << brk4_pkg::MEM_AW;
	localparam logic [DW-1:0] HI = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] LO = {1'b1, {(DW-1){1'b0}}};
	localparam logic [MW-1:0] MAG_HI = MW'(HI);
	localparam logic [MW-1:0] MAG_LO = MW'(LO);
	localparam logic [PW-1:0] HALF = PW'(1) << (FB - 1);
	localparam logic [DW-1:0] MINUS_ONE = DW'(brk4_pkg::minus_one(DW, FB));
	// floor(2^(DW+2)/6): reciprocal of six for the constant division
	localparam logic [DW+2:0] RECIP6_FULL = {1'b1, {(DW+2){1'b0}}} / (DW+3)'(6);
	localparam logic [DW-1:0] RECIP6 = RECIP6_FULL[DW-1:0];

	logic [DW-1:0] mem [MEM_DEPTH];

	logic [DW-1:0] r_q, u_q, v_q, w_q;
	logic          sat_q;
	logic [DW-1:0] mem_a_q, mem_b_q, ext_a_q, ext_b_q;
	logic          sel_a_q, sel_b_q;
	logic [PW-1:0] prod_q, rnd_q;
	logic [DW:0]   sum_q;
	logic [DW-1:0] x_q;
	logic          neg_q;
	logic [QW-1:0] q0_q;
	logic          ge_q;
	logic [DW-1:0] out_u_q, out_v_q, out_w_q;
	logic          out_ovf_q;

	logic [DW-1:0] ext_a, ext_b, opa, opb, ma, mb, xp3, mul_a, mul_b;
	logic [QW-1:0] q0;
	logic [DW-1:0] sixq, rem;
	logic [MW-1:0] m;
	logic [DW-1:0] q, wres;
	logic          wsat, ovf, rd_en, ex_en, po_en, wr_en;
	brk4_pkg::uop_t u;

	assign u     = cmd.uop;
	assign rd_en = cmd.run && (cmd.phase == brk4_pkg::PH_READ);
	assign ex_en = cmd.run && (cmd.phase == brk4_pkg::PH_EXEC);
	assign po_en = cmd.run && (cmd.phase == brk4_pkg::PH_POST);
	assign wr_en = cmd.run && (cmd.phase == brk4_pkg::PH_WRITE);

	// Operands held outside the scratch memory
	function automatic logic [DW-1:0] ext_val(input logic [brk4_pkg::OPD_W-1:0] code);
		logic [DW-1:0] v;
		case (code)
			brk4_pkg::O_TF: v = transition_freq;
			brk4_pkg::O_XI: v = dipole_asymmetry;
			brk4_pkg::O_R:  v = r_q;
			brk4_pkg::O_H:  v = DW'(step_size);
			brk4_pkg::O_HH: v = DW'(step_size[DW-2:1]);
			brk4_pkg::O_U:  v = u_q;
			brk4_pkg::O_V:  v = v_q;
			brk4_pkg::O_W:  v = w_q;
			default:        v = '0;
		endcase
		return v;
	endfunction

	// Select the outside operands, following every register the lookup reads
	always_comb begin
		ext_a = ext_val(u.src_a);
		ext_b = ext_val(u.src_b);
	end

	// Scratch memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en && !u.dst[brk4_pkg::OPD_W-1]) begin
			mem[u.dst[brk4_pkg::MEM_AW-1:0]] <= wres;
		end
		if (rd_en) begin
			mem_a_q <= mem[u.src_a[brk4_pkg::MEM_AW-1:0]];
			mem_b_q <= mem[u.src_b[brk4_pkg::MEM_AW-1:0]];
		end
	end

	// Register the outside operands alongside the memory read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			ext_a_q <= ext_a;
			ext_b_q <= ext_b;
			sel_a_q <= u.src_a[brk4_pkg::OPD_W-1];
			sel_b_q <= u.src_b[brk4_pkg::OPD_W-1];
		end
	end

	// Execute: magnitudes into the shared multiplier, exact sum
	always_comb begin
		opa   = sel_a_q ? ext_a_q : mem_a_q;
		opb   = sel_b_q ? ext_b_q : mem_b_q;
		ma    = opa[DW-1] ? ('0 - opa) : opa;
		mb    = opb[DW-1] ? ('0 - opb) : opb;
		xp3   = ma + DW'(3);
		mul_a = (u.op == brk4_pkg::OP_DIV6) ? xp3 : ma;
		mul_b = (u.op == brk4_pkg::OP_DIV6) ? RECIP6 : mb;
	end

	always_ff @(posedge clk) begin
		if (ex_en) begin
			prod_q <= PW'(mul_a) * PW'(mul_b);
			x_q    <= xp3;
			neg_q  <= (u.op == brk4_pkg::OP_DIV6) ? opa[DW-1] : (opa[DW-1] ^ opb[DW-1]);
			if (u.op == brk4_pkg::OP_NEG) begin
				sum_q <= (DW+1)'(0) - {opa[DW-1], opa};
			end else begin
				sum_q <= {opa[DW-1], opa} + {opb[DW-1], opb};
			end
		end
	end

	// Post: round the product, or estimate and correct the quotient by six
	always_comb begin
		q0   = prod_q[PW-1:DW+2];
		sixq = {q0, 2'b00} + DW'({q0, 1'b0});
		rem  = x_q - sixq;
	end

	always_ff @(posedge clk) begin
		if (po_en) begin
			rnd_q <= prod_q + HALF;
			q0_q  <= q0;
			ge_q  <= (rem >= DW'(6));
		end
	end

	// Write back: scale, saturate and sign the result
	always_comb begin
		m    = rnd_q[PW-1:FB];
		q    = DW'(q0_q) + DW'(ge_q);
		ovf  = sum_q[DW] ^ sum_q[DW-1];
		wres = '0;
		wsat = 1'b0;
		case (u.op)
			brk4_pkg::OP_MUL: begin
				if (neg_q) begin
					wsat = (m > MAG_LO);
					wres = wsat ? LO : ('0 - m[DW-1:0]);
				end else begin
					wsat = (m > MAG_HI);
					wres = wsat ? HI : m[DW-1:0];
				end
			end
			brk4_pkg::OP_DIV6: begin
				wres = neg_q ? ('0 - q) : q;
			end
			default: begin
				wsat = ovf;
				wres = ovf ? (sum_q[DW] ? LO : HI) : sum_q[DW-1:0];
			end
		endcase
	end

	// Hold the Bloch vector, the step's Rabi frequency and the saturation flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_q   <= '0;
			v_q   <= '0;
			w_q   <= MINUS_ONE;
			r_q   <= '0;
			sat_q <= 1'b0;
		end else if (cmd.start) begin
			r_q   <= rabi_freq;
			sat_q <= 1'b0;
			if (cmd.restart) begin
				u_q <= init_u;
				v_q <= init_v;
				w_q <= init_w;
			end
		end else if (wr_en) begin
			sat_q <= sat_q | wsat;
			case (u.dst)
				brk4_pkg::O_U: u_q <= wres;
				brk4_pkg::O_V: v_q <= wres;
				brk4_pkg::O_W: w_q <= wres;
				default: ;
			endcase
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_u_q   <= u_q;
			out_v_q   <= v_q;
			out_w_q   <= w_q;
			out_ovf_q <= sat_q;
		end
	end

	assign u_out    = out_u_q;
	assign v_out    = out_v_q;
	assign w_out    = out_w_q;
	assign overflow = out_ovf_q;

endmodule

/* sv/bloch_rk4_step_top.sv */
// Top level of the Bloch RK4 step block: registers, sequencer and datapath.
// Usage:
// - Input words on s_*: s_tdata holds rabi_freq, s_tuser holds restart. With
//   restart set, the Bloch vector is reloaded from init_u/v/w before stepping.
// - Each input word gives one output word on m_*: m_tdata holds u_out, v_out,
//   w_out from the lowest bits up, m_tuser holds the overflow flag.
// - Registers are written over the APB-style port at byte address 4*index
//   (8*index when DATA_WIDTH exceeds 32); the user must write them only
//   while no step is in flight, which the block itself does not enforce.
// - One step runs a 74-operation microprogram on one shared multiplier and
//   one saturating adder; each operation passes through memory read,
//   execute, round and write back, and the result word is then registered.
// - The output word sits in its own register: the next input word is taken
//   while it waits. If the receiver stalls past the next step, the block holds
//   that step's finished result and takes no input until the old word drains.
// - Reset sets u = v = 0, w = -1.0, step size h = 3676500, init_w = -1.0
//   and clears the other configuration registers; no result is pending after reset.
`include "bloch_rk4_step_top_assert.svh"
module bloch_rk4_step_top #(
	parameter int DATA_WIDTH = brk4_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = brk4_pkg::FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]         s_tdata,   // rabi_freq
	input  logic                                    s_tuser,   // restart
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [((3*DATA_WIDTH+7)/8)*8-1:0]       m_tdata,   // u_out, v_out, w_out
	output logic                                    m_tuser,   // overflow
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [((DATA_WIDTH > 32) ? 3 : 2)+2:0]  paddr,
	input  logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
	output logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] prdata,
	output logic                                    pready
);

	localparam int DW     = DATA_WIDTH;
	localparam int OUT_TW = ((3*DW+7)/8)*8;
	localparam int APB_DW = (DW > 32) ? 64 : 32;
	localparam int ASTEP  = (DW > 32) ? 3 : 2;
	localparam int AW     = ASTEP + brk4_pkg::REG_IDX_W;

	brk4_pkg::cmd_t cmd;
	logic [DW-1:0]  tf, xi, iu, iv, iw, u_out, v_out, w_out;
	logic [DW-2:0]  step;

	brk4_regs #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.APB_DW     (APB_DW),
		.ASTEP      (ASTEP),
		.AW         (AW)
	) u_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.transition_freq  (tf),
		.dipole_asymmetry (xi),
		.step_size        (step),
		.init_u           (iu),
		.init_v           (iv),
		.init_w           (iw)
	);

	brk4_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	brk4_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.rabi_freq        (s_tdata[DW-1:0]),
		.transition_freq  (tf),
		.dipole_asymmetry (xi),
		.step_size        (step),
		.init_u           (iu),
		.init_v           (iv),
		.init_w           (iw),
		.u_out            (u_out),
		.v_out            (v_out),
		.w_out            (w_out),
		.overflow         (m_tuser)
	);

	// Pack the result word, zero-filled to whole bytes
	assign m_tdata = OUT_TW'({w_out, v_out, u_out});

	// Checks
	`BRK4_ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`BRK4_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.out_load, !m_tvalid || m_tready)
	`BRK4_ASSERT_NXT(a_load_shows_word, clk, arst_n, cmd.out_load, m_tvalid)
	`BRK4_ASSERT_IMP(a_start_when_idle, clk, arst_n, cmd.start, !cmd.run)

endmodule
